FILE: rtl/border_padding_fetch_unit_macros.svh
// assertion helpers used by the controller
`ifndef BORDER_PADDING_FETCH_UNIT_MACROS_SVH
`define BORDER_PADDING_FETCH_UNIT_MACROS_SVH

// same-cycle implication on clock, disabled during reset
`define BPF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, disabled during reset
`define BPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bpf_pkg.sv
package bpf_pkg;

   // parameter defaults
   localparam int DEF_MAX_WIDTH    = 64;
   localparam int DEF_MAX_HEIGHT   = 64;
   localparam int DEF_MAX_PAD      = 63;
   localparam int DEF_ELEMENT_BITS = 32;

   // fixed field widths
   localparam int COORD_BITS   = 8;
   localparam int DATA_BITS    = 32;
   localparam int MODE_BITS    = 2;
   localparam int SIZE_BITS    = 7;
   localparam int PAD_BITS     = 6;
   localparam int STATUS_BITS  = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int REQ_TDATA_BITS = 48;
   localparam int RSP_TDATA_BITS = 40;

   // width of padded-axis arithmetic: pads and sizes sum to at most 253
   localparam int AXIS_BITS = 9;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAD_MODE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAD_LEFT     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAD_RIGHT    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAD_TOP      = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAD_BOTTOM   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILL_VALUE   = 3'd7;

   // register reset values
   localparam logic [SIZE_BITS-1:0] RESET_IMAGE_SIZE = 7'd64;

   // padding modes
   localparam logic [MODE_BITS-1:0] MODE_CONSTANT  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REFLECT   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_REPLICATE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED    = 2'd3;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_REFLECT   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OUT_RANGE = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic map;
      logic access;
      logic load_out;
   } bpf_cmd_type;

endpackage

FILE: rtl/bpf_datapath.sv
module bpf_datapath #(
   parameter int MAX_WIDTH    = bpf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = bpf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_PAD      = bpf_pkg::DEF_MAX_PAD,
   parameter int ELEMENT_BITS = bpf_pkg::DEF_ELEMENT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bpf_pkg::bpf_cmd_type                 cmd,
   // fields from bit 0: row[7:0], col[15:8], element[47:16]
   input  logic [bpf_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // fields: kind
   input  logic                                 req_tuser,
   input  logic                                 csr_we,
   input  logic [bpf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [bpf_pkg::DATA_BITS-1:0]        csr_wdata,
   // fields from bit 0: data[31:0], status[33:32], zero fill
   output logic [bpf_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // fields: from_fill
   output logic                                 rsp_tuser
);
   import bpf_pkg::*;

   localparam int Depth     = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrBits  = $clog2(Depth);
   localparam int StoreBits = (ELEMENT_BITS < DATA_BITS) ? ELEMENT_BITS : DATA_BITS;

   typedef enum logic [1:0] {
      AXIS_INSIDE,
      AXIS_BORDER,
      AXIS_OUTSIDE
   } axis_cls_type;

   typedef struct packed {
      axis_cls_type         cls;
      logic [AXIS_BITS-1:0] src;
   } axis_map_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ,
      OP_FILL
   } op_type;

   // configuration registers
   logic [MODE_BITS-1:0] mode_ff;
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [PAD_BITS-1:0]  pad_left_ff, pad_right_ff, pad_top_ff, pad_bottom_ff;
   logic [DATA_BITS-1:0] fill_ff;

   // captured request
   logic                  kind_ff;
   logic [COORD_BITS-1:0] row_ff, col_ff;
   logic [DATA_BITS-1:0]  element_ff;

   // mapped access
   logic [AddrBits-1:0]    addr_ff, addr_in;
   op_type                 op_ff, op_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   // store and its read register
   logic [StoreBits-1:0] store_mem [Depth];
   logic [StoreBits-1:0] rd_ff;

   // response registers
   logic [DATA_BITS-1:0]   rsp_data_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic                   rsp_fill_ff;

   // effective configuration
   logic [AXIS_BITS-1:0] w, h, pl, pr, pt, pb;
   logic [MODE_BITS-1:0] mode;
   logic                 reflect_err, load_ok;
   axis_map_type         map_r, map_c;

   function automatic logic [AXIS_BITS-1:0] size_clamp(input logic [SIZE_BITS-1:0] v,
                                                      input int max_v);
      logic [AXIS_BITS-1:0] r;
      if (v == '0) r = AXIS_BITS'(1);
      else if (int'(v) > max_v) r = AXIS_BITS'(max_v);
      else r = AXIS_BITS'(v);
      return r;
   endfunction

   function automatic logic [AXIS_BITS-1:0] pad_clamp(input logic [PAD_BITS-1:0] v);
      logic [AXIS_BITS-1:0] r;
      if (int'(v) > MAX_PAD) r = AXIS_BITS'(MAX_PAD);
      else r = AXIS_BITS'(v);
      return r;
   endfunction

   // padded index to image index on one axis
   function automatic axis_map_type map_axis(input logic [AXIS_BITS-1:0] p,
                                             input logic [AXIS_BITS-1:0] lead,
                                             input logic [AXIS_BITS-1:0] size,
                                             input logic [AXIS_BITS-1:0] after,
                                             input logic [MODE_BITS-1:0] md);
      axis_map_type r;
      r.src = '0;
      r.cls = AXIS_BORDER;
      if (p >= lead + size + after) begin
         r.cls = AXIS_OUTSIDE;
      end else if (p >= lead && p < lead + size) begin
         r.cls = AXIS_INSIDE;
         r.src = p - lead;
      end else if (md == MODE_REFLECT) begin
         r.cls = AXIS_INSIDE;
         if (p < lead) r.src = lead - p;
         else r.src = (size - 1'b1) + (size - 1'b1) - (p - lead);
      end else if (md == MODE_REPLICATE) begin
         r.cls = AXIS_INSIDE;
         r.src = (p < lead) ? '0 : size - 1'b1;
      end
      return r;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CONSTANT;
         width_ff      <= RESET_IMAGE_SIZE;
         height_ff     <= RESET_IMAGE_SIZE;
         pad_left_ff   <= '0;
         pad_right_ff  <= '0;
         pad_top_ff    <= '0;
         pad_bottom_ff <= '0;
         fill_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAD_MODE:     mode_ff       <= csr_wdata[MODE_BITS-1:0];
            CSR_IMAGE_WIDTH:  width_ff      <= csr_wdata[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff     <= csr_wdata[SIZE_BITS-1:0];
            CSR_PAD_LEFT:     pad_left_ff   <= csr_wdata[PAD_BITS-1:0];
            CSR_PAD_RIGHT:    pad_right_ff  <= csr_wdata[PAD_BITS-1:0];
            CSR_PAD_TOP:      pad_top_ff    <= csr_wdata[PAD_BITS-1:0];
            CSR_PAD_BOTTOM:   pad_bottom_ff <= csr_wdata[PAD_BITS-1:0];
            CSR_FILL_VALUE:   fill_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req_tuser;
         row_ff     <= req_tdata[COORD_BITS-1:0];
         col_ff     <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         element_ff <= req_tdata[2*COORD_BITS+DATA_BITS-1:2*COORD_BITS];
      end
   end

   // clamped sizes, pads and mode
   always_comb begin
      w    = size_clamp(width_ff, MAX_WIDTH);
      h    = size_clamp(height_ff, MAX_HEIGHT);
      pl   = pad_clamp(pad_left_ff);
      pr   = pad_clamp(pad_right_ff);
      pt   = pad_clamp(pad_top_ff);
      pb   = pad_clamp(pad_bottom_ff);
      mode = (mode_ff == MODE_UNUSED) ? MODE_CONSTANT : mode_ff;
      reflect_err = (mode == MODE_REFLECT) && (pl >= w || pr >= w || pt >= h || pb >= h);
      load_ok = (AXIS_BITS'(row_ff) < h) && (AXIS_BITS'(col_ff) < w);
      map_r = map_axis(AXIS_BITS'(row_ff), pt, h, pb, mode);
      map_c = map_axis(AXIS_BITS'(col_ff), pl, w, pr, mode);
   end

   // classify the request and form the store address
   always_comb begin
      op_in     = OP_NONE;
      status_in = STATUS_OK;
      addr_in   = AddrBits'(int'(row_ff) * MAX_WIDTH + int'(col_ff));
      if (kind_ff == KIND_LOAD) begin
         if (load_ok) op_in = OP_WRITE;
         else status_in = STATUS_OUT_RANGE;
      end else if (reflect_err) begin
         status_in = STATUS_REFLECT;
      end else if (map_r.cls == AXIS_OUTSIDE || map_c.cls == AXIS_OUTSIDE) begin
         status_in = STATUS_OUT_RANGE;
      end else if (map_r.cls == AXIS_BORDER || map_c.cls == AXIS_BORDER) begin
         op_in = OP_FILL;
      end else begin
         op_in   = OP_READ;
         addr_in = AddrBits'(int'(map_r.src) * MAX_WIDTH + int'(map_c.src));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.map) begin
         addr_ff   <= addr_in;
         op_ff     <= op_in;
         status_ff <= status_in;
      end
   end

   // store access
   always_ff @(posedge clock) begin
      if (cmd.access) begin
         if (op_ff == OP_WRITE) store_mem[addr_ff] <= element_ff[StoreBits-1:0];
         if (op_ff == OP_READ) rd_ff <= store_mem[addr_ff];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_fill_ff   <= (op_ff == OP_FILL);
         unique case (op_ff)
            OP_FILL: rsp_data_ff <= fill_ff;
            OP_READ: rsp_data_ff <= DATA_BITS'(rd_ff);
            default: rsp_data_ff <= '0;
         endcase
      end
   end

   assign rsp_tdata = {(RSP_TDATA_BITS-DATA_BITS-STATUS_BITS)'(0), rsp_status_ff, rsp_data_ff};
   assign rsp_tuser = rsp_fill_ff;

endmodule

FILE: rtl/bpf_controller.sv
`include "border_padding_fetch_unit_macros.svh"

module bpf_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output bpf_pkg::bpf_cmd_type cmd
);
   import bpf_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAP,
      S_ACCESS,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;
   logic      req_taken;

   // commands follow the state
   always_comb begin
      cmd.capture  = req_tvalid && ready_ff;
      cmd.map      = (state_ff == S_MAP);
      cmd.access   = (state_ff == S_ACCESS);
      cmd.load_out = (state_ff == S_OUT) && (!valid_ff || rsp_tready);
   end

   // next state and registered outputs
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (cmd.capture) state_in = S_MAP;
         S_MAP:    state_in = S_ACCESS;
         S_ACCESS: state_in = S_OUT;
         S_OUT:    if (cmd.load_out) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
      if (cmd.load_out) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   // input stays closed during reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;
   assign req_taken  = req_tvalid && req_tready;

   `BPF_ASSERT_NEXT(a_accept_closes_input, req_taken, !req_tready, "input open after accept")
   `BPF_ASSERT_NOW(a_map_after_accept, cmd.map, $past(req_taken), "map without accept")
   `BPF_ASSERT_NOW(a_access_after_map, cmd.access, $past(cmd.map), "access without map")
   `BPF_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, !valid_ff || rsp_tready, "overwrite")

endmodule

FILE: rtl/border_padding_fetch_unit.sv
// Padded read-out of a two-dimensional image store.
// Input channel req_: tuser carries the kind (load or fetch), tdata the row,
// column and element. A load writes one element of the unpadded image; a
// fetch names a position in the padded frame and returns one element in
// constant, reflect or replicate mode. Every request gives one response.
// Output channel rsp_: tdata carries data and status, tuser the fill flag.
// Registers are written through csr_we / csr_index / csr_wdata; the user must
// write them only while idle, and the block itself does not enforce this.
// A taken request passes address mapping, store access and the response
// register before its response is valid; the controller steps each request
// through mapping and the single store port before taking the next.
// A new request is taken while the previous response waits in its register;
// if the receiver stalls, that request waits before the response stage.
// Reset sets the registers to their defaults and empties the pipeline; the
// store contents stay undefined until loaded, and no clearing pass runs.
module border_padding_fetch_unit #(
   parameter int MAX_WIDTH    = bpf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = bpf_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_PAD      = bpf_pkg::DEF_MAX_PAD,
   parameter int ELEMENT_BITS = bpf_pkg::DEF_ELEMENT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // fields from bit 0: row[7:0], col[15:8], element[47:16]
   input  logic [bpf_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // fields: kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // fields from bit 0: data[31:0], status[33:32], zero fill
   output logic [bpf_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // fields: from_fill
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [bpf_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bpf_pkg::DATA_BITS-1:0]      csr_wdata
);
   import bpf_pkg::*;

   bpf_cmd_type cmd;

   bpf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bpf_datapath #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .MAX_PAD      (MAX_PAD),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

FILE: tb/sv/tb_border_padding_fetch_unit.sv
`timescale 1ns / 100ps

module tb_border_padding_fetch_unit;
   import bpf_pkg::*;

   localparam int STORE_WIDTH  = DEF_MAX_WIDTH;
   localparam int STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int SLOT_BITS    = $clog2(STORE_DEPTH);
   localparam int IDLE_PERCENT = 17;
   localparam int PHASE_COUNT  = 24;
   localparam int PHASE_ITEMS  = 80;

   typedef enum logic [1:0] {AXIS_INSIDE, AXIS_BORDER, AXIS_OUTSIDE} axis_class_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]   data;
      logic                   from_fill;
      logic [STATUS_BITS-1:0] status;
   } padded_element_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      req_tuser = KIND_LOAD;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = CSR_PAD_MODE;
   logic [DATA_BITS-1:0]      csr_wdata = '0;

   // shadow of the image store and of the registers
   logic [DATA_BITS-1:0] image_copy [STORE_DEPTH];
   bit                   image_loaded [STORE_DEPTH];
   logic [MODE_BITS-1:0] mode_reg = MODE_CONSTANT;
   logic [SIZE_BITS-1:0] width_reg = RESET_IMAGE_SIZE;
   logic [SIZE_BITS-1:0] height_reg = RESET_IMAGE_SIZE;
   logic [PAD_BITS-1:0]  pad_left_reg = '0;
   logic [PAD_BITS-1:0]  pad_right_reg = '0;
   logic [PAD_BITS-1:0]  pad_top_reg = '0;
   logic [PAD_BITS-1:0]  pad_bottom_reg = '0;
   logic [DATA_BITS-1:0] fill_reg = '0;

   padded_element_type expected_elements [$];
   int                 fail_count = 0;
   bit                 steady_flow = 1'b0;

   border_padding_fetch_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // effective sizes and pads
   function automatic int clamp_size(input logic [SIZE_BITS-1:0] v, input int max_size);
      if (v == 0) return 1;
      return (int'(v) > max_size) ? max_size : int'(v);
   endfunction

   function automatic int clamp_pad(input logic [PAD_BITS-1:0] v);
      return (int'(v) > DEF_MAX_PAD) ? DEF_MAX_PAD : int'(v);
   endfunction

   // one axis of the padded frame back to an image index
   function automatic axis_class_type map_axis(input int p, input int lead, input int span,
                                              input int after, input logic [MODE_BITS-1:0] mode,
                                              output int src);
      src = 0;
      if (p >= lead + span + after) return AXIS_OUTSIDE;
      if (p >= lead && p < lead + span) begin
         src = p - lead;
         return AXIS_INSIDE;
      end
      if (mode == MODE_REFLECT) begin
         src = (p < lead) ? lead - p : 2 * (span - 1) - (p - lead);
         return AXIS_INSIDE;
      end
      if (mode == MODE_REPLICATE) begin
         src = (p < lead) ? 0 : span - 1;
         return AXIS_INSIDE;
      end
      return AXIS_BORDER;
   endfunction

   // status of a fetch; when ok, either a border position or a store slot
   function automatic logic [STATUS_BITS-1:0] resolve_fetch(input logic [COORD_BITS-1:0] row,
                                                            input logic [COORD_BITS-1:0] col,
                                                            output bit on_border,
                                                            output int slot);
      int w, h, pl, pr, pt, pb, src_row, src_col;
      logic [MODE_BITS-1:0] mode;
      axis_class_type row_class, col_class;
      w = clamp_size(width_reg, DEF_MAX_WIDTH);
      h = clamp_size(height_reg, DEF_MAX_HEIGHT);
      pl = clamp_pad(pad_left_reg);
      pr = clamp_pad(pad_right_reg);
      pt = clamp_pad(pad_top_reg);
      pb = clamp_pad(pad_bottom_reg);
      mode = (mode_reg == MODE_UNUSED) ? MODE_CONSTANT : mode_reg;
      on_border = 1'b0;
      slot = 0;
      if (mode == MODE_REFLECT && (pl >= w || pr >= w || pt >= h || pb >= h))
         return STATUS_REFLECT;
      row_class = map_axis(int'(row), pt, h, pb, mode, src_row);
      col_class = map_axis(int'(col), pl, w, pr, mode, src_col);
      if (row_class == AXIS_OUTSIDE || col_class == AXIS_OUTSIDE) return STATUS_OUT_RANGE;
      on_border = (row_class == AXIS_BORDER || col_class == AXIS_BORDER);
      slot = src_row * STORE_WIDTH + src_col;
      return STATUS_OK;
   endfunction

   // response of one request, updating the shadow store on a load
   function automatic padded_element_type padded_read_out(input logic kind,
                                                         input logic [COORD_BITS-1:0] row,
                                                         input logic [COORD_BITS-1:0] col,
                                                         input logic [DATA_BITS-1:0] elem);
      padded_element_type r;
      bit on_border;
      int slot;
      r = '0;
      if (kind == KIND_LOAD) begin
         if (int'(row) < clamp_size(height_reg, DEF_MAX_HEIGHT) &&
             int'(col) < clamp_size(width_reg, DEF_MAX_WIDTH)) begin
            slot = int'(row) * STORE_WIDTH + int'(col);
            image_copy[SLOT_BITS'(slot)] = elem;
            image_loaded[SLOT_BITS'(slot)] = 1'b1;
         end else begin
            r.status = STATUS_OUT_RANGE;
         end
      end else begin
         r.status = resolve_fetch(row, col, on_border, slot);
         if (r.status == STATUS_OK) begin
            if (on_border) begin
               r.data = fill_reg;
               r.from_fill = 1'b1;
            end else begin
               r.data = image_copy[SLOT_BITS'(slot)];
            end
         end
      end
      return r;
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin : response_check
      padded_element_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_elements.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_elements.pop_front();
            if (rsp_tdata[DATA_BITS-1:0] !== want.data) begin
               $error("data expected %h actual %h", want.data, rsp_tdata[DATA_BITS-1:0]);
               fail_count++;
            end
            if (rsp_tuser !== want.from_fill) begin
               $error("from_fill expected %b actual %b", want.from_fill, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[DATA_BITS +: STATUS_BITS] !== want.status) begin
               $error("status expected %0d actual %0d", want.status,
                      rsp_tdata[DATA_BITS +: STATUS_BITS]);
               fail_count++;
            end
         end
      end
   end

   // one request; valid stays high afterwards until the bus is released
   task automatic send_request(input logic kind, input logic [COORD_BITS-1:0] row,
                               input logic [COORD_BITS-1:0] col,
                               input logic [DATA_BITS-1:0] elem);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {elem, col, row};
      do @(posedge clock); while (!req_tready);
      expected_elements = {expected_elements, padded_read_out(kind, row, col, elem)};
   endtask

   // fetch, loading the source element first if it was never written
   task automatic fetch_padded(input logic [COORD_BITS-1:0] row,
                               input logic [COORD_BITS-1:0] col);
      bit on_border;
      int slot;
      if (resolve_fetch(row, col, on_border, slot) == STATUS_OK && !on_border &&
          !image_loaded[SLOT_BITS'(slot)])
         send_request(KIND_LOAD, COORD_BITS'(slot / STORE_WIDTH),
                      COORD_BITS'(slot % STORE_WIDTH), $urandom);
      send_request(KIND_FETCH, row, col, $urandom);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_elements.size() != 0) @(posedge clock);
   endtask

   // register write with random bits above the register width
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index,
                                input logic [DATA_BITS-1:0] value, input int bits);
      logic [DATA_BITS-1:0] noise;
      noise = $urandom;
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= (noise << bits) | value;
      @(posedge clock);
      case (index)
         CSR_PAD_MODE:     mode_reg = value[MODE_BITS-1:0];
         CSR_IMAGE_WIDTH:  width_reg = value[SIZE_BITS-1:0];
         CSR_IMAGE_HEIGHT: height_reg = value[SIZE_BITS-1:0];
         CSR_PAD_LEFT:     pad_left_reg = value[PAD_BITS-1:0];
         CSR_PAD_RIGHT:    pad_right_reg = value[PAD_BITS-1:0];
         CSR_PAD_TOP:      pad_top_reg = value[PAD_BITS-1:0];
         CSR_PAD_BOTTOM:   pad_bottom_reg = value[PAD_BITS-1:0];
         CSR_FILL_VALUE:   fill_reg = value;
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [MODE_BITS-1:0] mode,
                                 input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
                                 input logic [PAD_BITS-1:0] pl, input logic [PAD_BITS-1:0] pr,
                                 input logic [PAD_BITS-1:0] pt, input logic [PAD_BITS-1:0] pb,
                                 input logic [DATA_BITS-1:0] fill);
      wait_for_responses();
      write_register(CSR_PAD_MODE, DATA_BITS'(mode), MODE_BITS);
      write_register(CSR_IMAGE_WIDTH, DATA_BITS'(w), SIZE_BITS);
      write_register(CSR_IMAGE_HEIGHT, DATA_BITS'(h), SIZE_BITS);
      write_register(CSR_PAD_LEFT, DATA_BITS'(pl), PAD_BITS);
      write_register(CSR_PAD_RIGHT, DATA_BITS'(pr), PAD_BITS);
      write_register(CSR_PAD_TOP, DATA_BITS'(pt), PAD_BITS);
      write_register(CSR_PAD_BOTTOM, DATA_BITS'(pb), PAD_BITS);
      write_register(CSR_FILL_VALUE, fill, DATA_BITS);
      csr_we <= 1'b0;
   endtask

   // default registers: store corners and loads outside the image
   task automatic test_load_bounds();
      send_request(KIND_LOAD, 0, 0, 32'h0000_0000);
      send_request(KIND_LOAD, 63, 63, 32'hFFFF_FFFF);
      send_request(KIND_LOAD, 64, 0, $urandom);
      send_request(KIND_LOAD, 0, 64, $urandom);
      send_request(KIND_LOAD, 255, 255, 32'hFFFF_FFFF);
      fetch_padded(0, 0);
      fetch_padded(63, 63);
      fetch_padded(64, 5);
      fetch_padded(0, 255);
   endtask

   // width of zero acts as one, height above the maximum acts as the maximum
   task automatic test_size_clamp();
      write_settings(MODE_CONSTANT, 0, 127, 0, 0, 0, 0, $urandom);
      send_request(KIND_LOAD, 10, 1, $urandom);
      send_request(KIND_LOAD, 63, 0, $urandom);
      fetch_padded(63, 0);
      fetch_padded(0, 1);
      fetch_padded(64, 0);
   endtask

   // unused mode behaves as constant fill
   task automatic test_unused_mode();
      write_settings(MODE_UNUSED, 2, 2, 1, 1, 1, 1, 32'hA5A5_5A5A);
      fetch_padded(0, 0);
      fetch_padded(2, 2);
      fetch_padded(3, 3);
      fetch_padded(4, 1);
   endtask

   // reflection at both corners, reflect error over a coordinate error,
   // replication of a single element under the widest pads
   task automatic test_reflect_replicate();
      write_settings(MODE_REFLECT, 4, 3, 3, 3, 2, 2, $urandom);
      fetch_padded(0, 0);
      fetch_padded(6, 9);
      fetch_padded(7, 0);
      write_settings(MODE_REFLECT, 4, 3, 0, 0, 0, 3, $urandom);
      fetch_padded(0, 0);
      fetch_padded(255, 255);
      write_settings(MODE_REPLICATE, 1, 1, 63, 63, 63, 63, $urandom);
      fetch_padded(126, 126);
      fetch_padded(127, 0);
   endtask

   function automatic logic [SIZE_BITS-1:0] random_size();
      int roll = $urandom_range(99);
      if (roll < 70) return SIZE_BITS'($urandom_range(1, 8));
      if (roll < 85) return SIZE_BITS'($urandom_range(1, 64));
      if (roll < 92) return 0;
      return SIZE_BITS'($urandom_range(65, 127));
   endfunction

   // reflect mode mostly gets pads below the axis size
   function automatic logic [PAD_BITS-1:0] random_pad(input logic [MODE_BITS-1:0] mode,
                                                      input int span);
      int roll = $urandom_range(99);
      if (mode == MODE_REFLECT && roll < 95) return PAD_BITS'($urandom_range(0, span - 1));
      if (roll < 70) return PAD_BITS'($urandom_range(0, 4));
      if (roll < 85) return PAD_BITS'(DEF_MAX_PAD);
      return PAD_BITS'($urandom_range(0, DEF_MAX_PAD));
   endfunction

   task automatic random_request();
      int w, h, rows, cols, roll;
      w = clamp_size(width_reg, DEF_MAX_WIDTH);
      h = clamp_size(height_reg, DEF_MAX_HEIGHT);
      rows = clamp_pad(pad_top_reg) + h + clamp_pad(pad_bottom_reg);
      cols = clamp_pad(pad_left_reg) + w + clamp_pad(pad_right_reg);
      roll = $urandom_range(99);
      if (roll < 15)
         send_request(KIND_LOAD, COORD_BITS'($urandom_range(h - 1)),
                      COORD_BITS'($urandom_range(w - 1)), $urandom);
      else if (roll < 20)
         send_request(KIND_LOAD, COORD_BITS'($urandom_range(255)),
                      COORD_BITS'($urandom_range(255)), $urandom);
      else if (roll < 28)
         fetch_padded(COORD_BITS'($urandom_range(255)), COORD_BITS'($urandom_range(255)));
      else
         fetch_padded(COORD_BITS'($urandom_range(rows - 1)),
                      COORD_BITS'($urandom_range(cols - 1)));
   endtask

   // random traffic over a series of settings, extremes first
   task automatic test_random_settings();
      logic [MODE_BITS-1:0] mode;
      logic [SIZE_BITS-1:0] w, h;
      logic [PAD_BITS-1:0]  pl, pr, pt, pb;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mode = MODE_BITS'($urandom_range(3));
         w = random_size();
         h = random_size();
         pl = random_pad(mode, clamp_size(w, DEF_MAX_WIDTH));
         pr = random_pad(mode, clamp_size(w, DEF_MAX_WIDTH));
         pt = random_pad(mode, clamp_size(h, DEF_MAX_HEIGHT));
         pb = random_pad(mode, clamp_size(h, DEF_MAX_HEIGHT));
         case (phase)
            0: {mode, w, h, pl, pr, pt, pb} = {MODE_CONSTANT, 7'd64, 7'd64, {4{6'd63}}};
            1: {mode, w, h, pl, pr, pt, pb} = {MODE_REPLICATE, 7'd64, 7'd64, {4{6'd63}}};
            2: {mode, w, h, pl, pr, pt, pb} = {MODE_REFLECT, 7'd64, 7'd64, {4{6'd63}}};
            3: {mode, w, h, pl, pr, pt, pb} = {MODE_REFLECT, 7'd1, 7'd1, {4{6'd0}}};
            default: ;
         endcase
         write_settings(mode, w, h, pl, pr, pt, pb, $urandom);
         steady_flow = (phase == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off until the pipeline has drained
            if (phase == 9 && n == PHASE_ITEMS / 2) wait_for_responses();
            random_request();
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_load_bounds();
      test_size_clamp();
      test_unused_mode();
      test_reflect_replicate();
      test_random_settings();
      wait_for_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_elements.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/bpf_pkg.sv
rtl/bpf_datapath.sv
rtl/bpf_controller.sv
rtl/border_padding_fetch_unit.sv
tb/sv/tb_border_padding_fetch_unit.sv
